### sv/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MRBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define MRBP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### sv/mrbp_pkg.sv
package mrbp_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int COEF_BITS_DEF    = 16;

  // Fixed field widths
  localparam int CH_CFG_W  = 5;
  localparam int CH_OUT_W  = 4;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam int CH_CFG_RESET = 1;
  localparam int COEF_RESET   = 32768;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HP_COEF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LP_COEF  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_HP_SAT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LP_RANGE = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HP_MUL,
    ST_HP_CLAMP,
    ST_LP_MUL,
    ST_LP_DONE
  } state_t;

endpackage

### sv/mrbp_ram.sv
module mrbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/multichannel_rc_band_pass.sv
// An input word runs through HP_MUL, HP_CLAMP, LP_MUL and LP_DONE; the result is
// registered in LP_DONE once the output can move, and only then is a new word taken,
// as the shared coefficient multiplier and the channel state read-modify-write need.
// Reset (rst_n low, synchronous) sets the registers to 1 channel and alphas of
// one half, restarts the channel counter and marks every channel unprimed.
`include "assert_macros.svh"

module multichannel_rc_band_pass #(
  parameter int MAX_CHANNELS = mrbp_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = mrbp_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = mrbp_pkg::COEF_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int CFG_W = (COEF_BITS > mrbp_pkg::CH_CFG_W) ? COEF_BITS : mrbp_pkg::CH_CFG_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic [1:0]                     in_tuser,   // [0] buffer_start, [1] clear_state
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // [SAMPLE_BITS-1:0] filtered
  output logic [mrbp_pkg::CH_OUT_W+mrbp_pkg::STATUS_W-1:0] out_tuser, // [3:0] channel, [5:4] status
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  import mrbp_pkg::*;

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W = (CNT_W > CH_CFG_W) ? CNT_W : CH_CFG_W;
  localparam int HP_W  = SAMPLE_BITS + 2;
  localparam int D_W   = SAMPLE_BITS + 3;
  localparam int P_W   = D_W + COEF_BITS + 1;
  localparam int R_W   = P_W - COEF_BITS;
  localparam int LP_W  = SAMPLE_BITS + 5;
  localparam int ST_W  = 3 * SAMPLE_BITS + 2;

  localparam logic [P_W-1:0] RND_HALF =
    {{(P_W - COEF_BITS){1'b0}}, 1'b1, {(COEF_BITS - 1){1'b0}}};
  localparam logic signed [R_W-1:0] HP_MAX = {3'b000, {(SAMPLE_BITS + 1){1'b1}}};
  localparam logic signed [R_W-1:0] HP_MIN = {3'b111, {(SAMPLE_BITS + 1){1'b0}}};
  localparam logic signed [LP_W-1:0] FS_POS =
    {{(LP_W - SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic signed [LP_W-1:0] FS_NEG = -FS_POS;

  // Configuration registers
  logic [CH_CFG_W-1:0]  chans_r;
  logic [COEF_BITS-1:0] hp_coef_r;
  logic [COEF_BITS-1:0] lp_coef_r;

  // Control
  state_t                state_r, state_nxt;
  logic [CH_W-1:0]       cnt_r, cnt_nxt;
  logic [MAX_CHANNELS-1:0] primed_r, primed_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic                  fwd_hit_r;

  // Payload
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [CH_W-1:0]               ch_r;
  logic [ST_W-1:0]               st_r;
  logic                          prim_r;
  logic signed [P_W-1:0]         prod_r;
  logic signed [HP_W-1:0]        hp_r;
  logic                          sat_r;
  logic [ST_W-1:0]               fwd_data_r;
  logic [SAMPLE_BITS-1:0]        out_filt_r;
  logic [CH_OUT_W-1:0]           out_ch_r;
  logic [STATUS_W-1:0]           out_status_r;

  // Datapath nets
  logic                          in_acc;
  logic                          out_go;
  logic [CMP_W-1:0]              chans_ext, count_eff, inc;
  logic [CH_W-1:0]               base, ch_sel;
  logic [ST_W-1:0]               rd_data, st_sel;
  logic signed [SAMPLE_BITS-1:0] li_sel, llp_r;
  logic signed [HP_W-1:0]        lhp_sel;
  logic signed [D_W-1:0]         diff1, diff2, mul_a;
  logic signed [COEF_BITS:0]     mul_b;
  logic signed [P_W-1:0]         prod_nxt, rnd_sum;
  logic signed [R_W-1:0]         rnd_q;
  logic signed [LP_W-1:0]        lp, lp_out;
  logic                          lp_err;
  logic                          wr_en;
  logic [ST_W-1:0]               wr_data;
  logic [SAMPLE_BITS-1:0]        filt;
  logic [STATUS_W-1:0]           status;

  // Registers change only with no sample in flight and none being offered
  assign cfg_ready = (state_r == ST_IDLE) && !in_tvalid;
  assign in_acc    = in_tvalid && in_tready;
  assign out_go    = !out_tvalid_r || out_tready;

  // Register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r   <= CH_CFG_W'(CH_CFG_RESET);
      hp_coef_r <= COEF_BITS'(COEF_RESET);
      lp_coef_r <= COEF_BITS'(COEF_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHANNELS: chans_r   <= cfg_data[CH_CFG_W-1:0];
        REG_HP_COEF:  hp_coef_r <= cfg_data[COEF_BITS-1:0];
        REG_LP_COEF:  lp_coef_r <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Channel count: zero acts as one, clipped to the channel storage
  always_comb begin
    chans_ext = CMP_W'(chans_r);
    if (chans_ext == '0) begin
      count_eff = CMP_W'(1);
    end else if (chans_ext > CMP_W'(MAX_CHANNELS)) begin
      count_eff = CMP_W'(MAX_CHANNELS);
    end else begin
      count_eff = chans_ext;
    end
  end

  // Channel of the incoming word and the counter after it
  always_comb begin
    base = in_tuser[0] ? '0 : cnt_r;
    ch_sel = (CMP_W'(base) >= count_eff) ? '0 : base;
    inc = CMP_W'(ch_sel) + CMP_W'(1);
    cnt_nxt = (inc >= count_eff) ? '0 : CH_W'(inc);
  end

  // Channel state: {last_low_pass, last_high_pass, last_input}
  mrbp_ram #(
    .WIDTH (ST_W),
    .DEPTH (MAX_CHANNELS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ch_r),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (ch_sel),
    .rd_data (rd_data)
  );

  // Read data, or the word written back as this one was read
  assign st_sel  = fwd_hit_r ? fwd_data_r : rd_data;
  assign li_sel  = st_sel[SAMPLE_BITS-1:0];
  assign lhp_sel = st_sel[2*SAMPLE_BITS+1:SAMPLE_BITS];
  assign llp_r   = st_r[3*SAMPLE_BITS+1:2*SAMPLE_BITS+2];

  // Differences feeding the shared multiplier
  assign diff1 = D_W'(lhp_sel) + D_W'(x_r) - D_W'(li_sel);
  assign diff2 = D_W'(hp_r) - D_W'(llp_r);

  always_comb begin
    if (state_r == ST_HP_MUL) begin
      mul_a = diff1;
      mul_b = signed'({1'b0, hp_coef_r});
    end else begin
      mul_a = diff2;
      mul_b = signed'({1'b0, lp_coef_r});
    end
    prod_nxt = P_W'(mul_a) * P_W'(mul_b);
  end

  // Round half up and drop the coefficient fraction
  assign rnd_sum = prod_r + signed'(RND_HALF);
  assign rnd_q   = rnd_sum[P_W-1:COEF_BITS];

  // Low-pass sum and range check
  always_comb begin
    lp     = LP_W'(llp_r) + LP_W'(rnd_q);
    lp_err = (lp < FS_NEG) || (lp > FS_POS);
    lp_out = (lp == FS_POS) ? (FS_POS - LP_W'(1)) : lp;
  end

  // Result and write-back word
  always_comb begin
    if (!prim_r) begin
      filt    = '0;
      status  = STATUS_OK;
      wr_data = {{(2 * SAMPLE_BITS + 2){1'b0}}, x_r};
    end else if (lp_err) begin
      filt    = '0;
      status  = STATUS_LP_RANGE;
      wr_data = st_r;
    end else begin
      filt    = lp_out[SAMPLE_BITS-1:0];
      status  = sat_r ? STATUS_HP_SAT : STATUS_OK;
      wr_data = {lp_out[SAMPLE_BITS-1:0], hp_r, x_r};
    end
  end

  // Sequencer: next state, handshake and write enable
  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    wr_en          = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_HP_MUL;
        end
      end
      ST_HP_MUL: begin
        state_nxt = ST_HP_CLAMP;
      end
      ST_HP_CLAMP: begin
        state_nxt = ST_LP_MUL;
      end
      ST_LP_MUL: begin
        state_nxt = ST_LP_DONE;
      end
      ST_LP_DONE: begin
        if (out_go) begin
          in_tready      = 1'b1;
          wr_en          = !prim_r || !lp_err;
          out_tvalid_nxt = 1'b1;
          state_nxt      = in_tvalid ? ST_HP_MUL : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Primed flags: set on write-back, cleared by a clearing buffer start
  always_comb begin
    primed_nxt = primed_r;
    if (wr_en) begin
      primed_nxt[ch_r] = 1'b1;
    end
    if (in_acc && in_tuser[0] && in_tuser[1]) begin
      primed_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      primed_r     <= '0;
      out_tvalid_r <= 1'b0;
      fwd_hit_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      primed_r     <= primed_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      fwd_hit_r    <= in_acc && wr_en && (ch_sel == ch_r);
      if (in_acc) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r        <= in_tdata[SAMPLE_BITS-1:0];
      ch_r       <= ch_sel;
      fwd_data_r <= wr_data;
    end
    case (state_r)
      ST_HP_MUL: begin
        st_r   <= st_sel;
        prim_r <= primed_r[ch_r];
        prod_r <= prod_nxt;
      end
      ST_HP_CLAMP: begin
        if (rnd_q > HP_MAX) begin
          hp_r  <= HP_MAX[HP_W-1:0];
          sat_r <= 1'b1;
        end else if (rnd_q < HP_MIN) begin
          hp_r  <= HP_MIN[HP_W-1:0];
          sat_r <= 1'b1;
        end else begin
          hp_r  <= rnd_q[HP_W-1:0];
          sat_r <= 1'b0;
        end
      end
      ST_LP_MUL: begin
        prod_r <= prod_nxt;
      end
      ST_LP_DONE: begin
        if (out_go) begin
          out_filt_r   <= filt;
          out_ch_r     <= CH_OUT_W'(ch_r);
          out_status_r <= status;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(out_filt_r);
  assign out_tuser  = {out_status_r, out_ch_r};

  // Checks
  `MRBP_ASSERT(a_acc_state, in_acc |-> (state_r == ST_IDLE || state_r == ST_LP_DONE),
    "word taken while a sample is in flight")
  `MRBP_ASSERT(a_fwd_slot, fwd_hit_r |-> (state_r == ST_HP_MUL),
    "forwarded state word outside the read slot")
  `MRBP_ASSERT(a_wr_slot, wr_en |-> (state_r == ST_LP_DONE && out_go),
    "state write outside the write-back slot")
  `MRBP_ASSERT(a_err_zero, (out_tvalid_r && out_status_r == STATUS_LP_RANGE)
    |-> (out_filt_r == '0), "range error with non-zero output")
  `MRBP_NEVER(a_ch_range, (state_r != ST_IDLE) && (CMP_W'(ch_r) >= count_eff),
    "channel beyond the channel count")

endmodule
